[design/multi_led_blink_controller_defines.svh]
// Assertion macros shared by the checker of the multi-LED blink controller.
// No dependencies; include by bare file name.
`ifndef MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MLBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MLBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mlbc_pkg.sv]
// Shared types and constants of the multi-LED blink controller.
// No dependencies; used by the interfaces and all modules.
package mlbc_pkg;

    // Fixed field widths
    localparam int LED_FIELD_BITS = 3;   // LEDs with a register and result bit
    localparam int LED_INDEX_BITS = 2;
    localparam int LED_ID_BITS    = 3;   // wide enough for lane numbers 0 to 7
    localparam int MODE_BITS      = 2;
    localparam int FIELD_TIME_BITS = 16;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    // Item operation
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } t_op;

    // LED mode; code 3 is stored but never acted on
    typedef enum logic [MODE_BITS-1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2
    } t_led_mode;

    // Configuration register index (address bit 2)
    typedef enum logic [0:0] {
        REG_LED_PRESENT = 1'b0,
        REG_ACTIVE_HIGH = 1'b1
    } t_reg_idx;

    localparam logic [LED_FIELD_BITS-1:0] PRESENT_RESET     = 3'd0;
    localparam logic [LED_FIELD_BITS-1:0] ACTIVE_HIGH_RESET = 3'd7;

    // Per-lane command for one item
    typedef struct packed {
        logic      set;
        logic      tick;
        t_led_mode mode;
    } t_lane_cmd;

endpackage

[design/mlbc_in_if.sv]
// Input item channel of the multi-LED blink controller.
// Depends on mlbc_pkg.
interface mlbc_in_if;
    import mlbc_pkg::*;

    logic                       valid;
    logic                       ready;
    t_op                        op;
    logic [LED_INDEX_BITS-1:0]  led_index;
    logic [MODE_BITS-1:0]       mode;
    logic [FIELD_TIME_BITS-1:0] on_time;
    logic [FIELD_TIME_BITS-1:0] dark_time;
    logic [FIELD_TIME_BITS-1:0] blink_span;

    modport source (
        output valid, op, led_index, mode, on_time, dark_time, blink_span,
        input  ready
    );
    modport sink (
        input  valid, op, led_index, mode, on_time, dark_time, blink_span,
        output ready
    );
endinterface

[design/mlbc_out_if.sv]
// Result item channel of the multi-LED blink controller.
// Depends on mlbc_pkg.
interface mlbc_out_if;
    import mlbc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [LED_FIELD_BITS-1:0] pin_levels;
    logic [LED_FIELD_BITS-1:0] lit_mask;

    modport source (
        output valid, pin_levels, lit_mask,
        input  ready
    );
    modport sink (
        input  valid, pin_levels, lit_mask,
        output ready
    );
endinterface

[design/mlbc_apb_regs.sv]
// APB configuration registers: LED present mask and polarity mask.
// Depends on mlbc_pkg.
module mlbc_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mlbc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [mlbc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mlbc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [mlbc_pkg::LED_FIELD_BITS-1:0] o_present_mask,
    output logic [mlbc_pkg::LED_FIELD_BITS-1:0] o_active_high_mask
);
    import mlbc_pkg::*;

    logic [LED_FIELD_BITS-1:0] r_present;
    logic [LED_FIELD_BITS-1:0] r_active_high;
    t_reg_idx                  w_idx;
    logic                      w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present     <= PRESENT_RESET;
            r_active_high <= ACTIVE_HIGH_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_LED_PRESENT: r_present     <= pwdata[LED_FIELD_BITS-1:0];
                REG_ACTIVE_HIGH: r_active_high <= pwdata[LED_FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            REG_LED_PRESENT: prdata = APB_DATA_BITS'(r_present);
            REG_ACTIVE_HIGH: prdata = APB_DATA_BITS'(r_active_high);
            default:         prdata = '0;
        endcase
    end

    assign o_present_mask     = r_present;
    assign o_active_high_mask = r_active_high;

endmodule

[design/mlbc_led_lane.sv]
// State and update logic of one LED: mode, pending flag, blink timing.
// Depends on mlbc_pkg.
module mlbc_led_lane #(
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mlbc_pkg::t_lane_cmd   i_cmd,
    input  logic [TIME_BITS-1:0]  i_on_time,
    input  logic [TIME_BITS-1:0]  i_dark_time,
    input  logic [TIME_BITS-1:0]  i_blink_span,
    output logic                  o_lit_next
);
    import mlbc_pkg::*;

    t_led_mode            r_mode,    n_mode;
    logic                 r_pending, n_pending;
    logic [TIME_BITS-1:0] r_phase,   n_phase;
    logic [TIME_BITS-1:0] r_on,      n_on;
    logic [TIME_BITS-1:0] r_off,     n_off;
    logic [TIME_BITS-1:0] r_left,    n_left;
    logic                 r_lit,     n_lit;

    logic [TIME_BITS:0]   w_period;
    logic [TIME_BITS:0]   w_step;
    logic                 w_wrap;
    logic [TIME_BITS-1:0] w_phase_adv;

    // Phase advance: wrap at the period, on a zero period, or on overflow
    assign w_period    = (TIME_BITS+1)'(r_on) + (TIME_BITS+1)'(r_off);
    assign w_step      = (TIME_BITS+1)'(r_phase) + (TIME_BITS+1)'(1);
    assign w_wrap      = (w_period == '0) || (w_step >= w_period) || w_step[TIME_BITS];
    assign w_phase_adv = w_wrap ? '0 : w_step[TIME_BITS-1:0];

    // Next state for a set-mode or tick item
    always_comb begin
        n_mode    = r_mode;
        n_pending = r_pending;
        n_phase   = r_phase;
        n_on      = r_on;
        n_off     = r_off;
        n_left    = r_left;
        n_lit     = r_lit;
        if (i_cmd.set) begin
            n_mode    = i_cmd.mode;
            n_pending = 1'b1;
            n_phase   = '0;
            if (i_cmd.mode == MODE_BLINK) begin
                n_on   = i_on_time;
                n_off  = i_dark_time;
                n_left = i_blink_span;
            end
        end else if (i_cmd.tick && r_pending) begin
            case (r_mode)
                MODE_OFF: begin
                    n_lit     = 1'b0;
                    n_pending = 1'b0;
                end
                MODE_ON: begin
                    n_lit     = 1'b1;
                    n_pending = 1'b0;
                end
                MODE_BLINK: begin
                    if (r_left == '0) begin
                        n_lit     = 1'b0;
                        n_mode    = MODE_OFF;
                        n_pending = 1'b0;
                    end else begin
                        n_left  = r_left - TIME_BITS'(1);
                        n_phase = w_phase_adv;
                        n_lit   = (w_phase_adv <= r_on);
                    end
                end
                default: ;  // undefined mode: hold and stay pending
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_pending <= 1'b1;
            r_phase   <= '0;
            r_on      <= '0;
            r_off     <= '0;
            r_left    <= '0;
            r_lit     <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_phase   <= n_phase;
            r_on      <= n_on;
            r_off     <= n_off;
            r_left    <= n_left;
            r_lit     <= n_lit;
        end
    end

    assign o_lit_next = n_lit;

endmodule

[design/multi_led_blink_controller.sv]
// Multi-LED blink controller: input register, per-LED lanes, result register.
// An accepted item is held in the input register; its result is then registered in the result register.
// Throughput: one item per cycle while the result channel is not stalled; all present LED lanes update in parallel.
// Reset (synchronous, active low): LEDs off, dark and pending, present mask 0,
// polarity mask all active high, both channel stages empty.
// Depends on mlbc_pkg, mlbc_in_if, mlbc_out_if, mlbc_apb_regs, mlbc_led_lane.
module multi_led_blink_controller #(
    parameter int NUM_LEDS  = 3,
    parameter int TIME_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mlbc_in_if.sink                             i_item,
    mlbc_out_if.source                          o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mlbc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [mlbc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mlbc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import mlbc_pkg::*;

    // Input register
    logic                       r_in_valid;
    t_op                        r_op;
    logic [LED_INDEX_BITS-1:0]  r_idx;
    logic [MODE_BITS-1:0]       r_mode;
    logic [FIELD_TIME_BITS-1:0] r_on;
    logic [FIELD_TIME_BITS-1:0] r_off;
    logic [FIELD_TIME_BITS-1:0] r_blink;

    // Result register
    logic                      r_out_valid;
    logic [LED_FIELD_BITS-1:0] r_pins;
    logic [LED_FIELD_BITS-1:0] r_lits;

    logic                      w_adv;
    logic [LED_FIELD_BITS-1:0] w_present_mask;
    logic [LED_FIELD_BITS-1:0] w_active_high;
    logic [NUM_LEDS-1:0]       w_present;
    logic [NUM_LEDS-1:0]       w_lit_next;
    logic [LED_FIELD_BITS-1:0] w_pins;
    logic [LED_FIELD_BITS-1:0] w_lits;

    mlbc_apb_regs u_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_present_mask     (w_present_mask),
        .o_active_high_mask (w_active_high)
    );

    // Advance the held item when the result register is free or being drained
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op    <= i_item.op;
            r_idx   <= i_item.led_index;
            r_mode  <= i_item.mode;
            r_on    <= i_item.on_time;
            r_off   <= i_item.dark_time;
            r_blink <= i_item.blink_span;
        end
    end

    // One lane per LED; LEDs past the register width count as absent
    for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
        localparam logic [LED_ID_BITS-1:0] LaneId = LED_ID_BITS'(i);
        t_lane_cmd w_cmd;

        if (i < LED_FIELD_BITS) begin : g_fitted
            assign w_present[i] = w_present_mask[i];
        end else begin : g_absent
            assign w_present[i] = 1'b0;
        end

        assign w_cmd.set  = w_adv && (r_op == OP_SET) && w_present[i]
                            && ({1'b0, r_idx} == LaneId);
        assign w_cmd.tick = w_adv && (r_op == OP_TICK) && w_present[i];
        assign w_cmd.mode = t_led_mode'(r_mode);

        mlbc_led_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_on_time    (TIME_BITS'(r_on)),
            .i_dark_time  (TIME_BITS'(r_off)),
            .i_blink_span (TIME_BITS'(r_blink)),
            .o_lit_next   (w_lit_next[i])
        );
    end

    // Form result bits; polarity applied to present LEDs only
    for (genvar j = 0; j < LED_FIELD_BITS; j++) begin : g_res
        if (j < NUM_LEDS) begin : g_used
            assign w_lits[j] = w_present[j] & w_lit_next[j];
            assign w_pins[j] = w_present[j] & (w_lit_next[j] ^ ~w_active_high[j]);
        end else begin : g_unused
            assign w_lits[j] = 1'b0;
            assign w_pins[j] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pins <= w_pins;
            r_lits <= w_lits;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.pin_levels = r_pins;
    assign o_result.lit_mask   = r_lits;

endmodule

[design/mlbc_checker.sv]
// Port-level checker of the multi-LED blink controller, bound to the top level.
// Depends on mlbc_pkg and multi_led_blink_controller_defines.svh.
`include "multi_led_blink_controller_defines.svh"

module mlbc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_psel,
    input logic                                i_penable,
    input logic                                i_pwrite,
    input logic                                i_pready,
    input logic [mlbc_pkg::APB_ADDR_BITS-1:0]  i_paddr,
    input logic [mlbc_pkg::APB_DATA_BITS-1:0]  i_pwdata,
    input logic [mlbc_pkg::APB_DATA_BITS-1:0]  i_prdata,
    input logic                                i_res_valid,
    input logic                                i_res_ready,
    input logic [mlbc_pkg::LED_FIELD_BITS-1:0] i_pin_levels,
    input logic [mlbc_pkg::LED_FIELD_BITS-1:0] i_lit_mask
);
    import mlbc_pkg::*;

    logic [LED_FIELD_BITS-1:0] r_present;
    logic [LED_FIELD_BITS-1:0] r_active_high;

    // Track the configuration from completed writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present     <= PRESENT_RESET;
            r_active_high <= ACTIVE_HIGH_RESET;
        end else if (i_psel && i_penable && i_pwrite && i_pready) begin
            if (i_paddr[2] == REG_LED_PRESENT) begin
                r_present <= i_pwdata[LED_FIELD_BITS-1:0];
            end else begin
                r_active_high <= i_pwdata[LED_FIELD_BITS-1:0];
            end
        end
    end

    `MLBC_ASSERT_NOW(a_pins_match_lits, i_clk, i_rst_n, i_res_valid,
        i_pin_levels == ((i_lit_mask ^ ~r_active_high) & r_present),
        "pin levels disagree with lit mask and polarity")

    `MLBC_ASSERT_NOW(a_absent_dark, i_clk, i_rst_n, i_res_valid,
        (i_lit_mask & ~r_present) == '0,
        "absent LED reported lit")

    `MLBC_ASSERT_NOW(a_read_present, i_clk, i_rst_n,
        i_psel && !i_pwrite && (i_paddr[2] == REG_LED_PRESENT),
        i_prdata == APB_DATA_BITS'(r_present),
        "present mask read back wrong")

    `MLBC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_pin_levels) && $stable(i_lit_mask),
        "stalled result changed")

endmodule

bind multi_led_blink_controller mlbc_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_pready     (pready),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata),
    .i_res_valid  (o_result.valid),
    .i_res_ready  (o_result.ready),
    .i_pin_levels (o_result.pin_levels),
    .i_lit_mask   (o_result.lit_mask)
);
